// ===== rtl/core/ryc_pkg.sv =====
package ryc_pkg;

	localparam int PIX_W          = 8;
	localparam int REG_W          = 13;
	localparam int LIM_W          = 15;
	localparam int LUMA_ADDR_W    = 24;
	localparam int CHROMA_ADDR_W  = 22;
	localparam int CFG_INDEX_W    = 1;

	localparam int DEF_MAX_WIDTH    = 4096;
	localparam int DEF_MAX_HEIGHT   = 4096;
	localparam int DEF_FRAME_WIDTH  = 640;
	localparam int DEF_FRAME_HEIGHT = 480;

	localparam int MIN_FRAME_WIDTH  = 2;
	localparam int MIN_FRAME_HEIGHT = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// position of one pixel in the output planes
	typedef struct packed {
		logic [LUMA_ADDR_W-1:0]   luma_address;
		logic                     chroma_valid;
		logic [CHROMA_ADDR_W-1:0] chroma_address;
		logic                     frame_end;
	} pos_t;

	// saturate v to lo..hi and return the result minus one
	function automatic logic [LIM_W-1:0] clamp_m1(
		input logic [LIM_W-1:0] v,
		input logic [LIM_W-1:0] lo,
		input logic [LIM_W-1:0] hi
	);
		logic [LIM_W-1:0] c;
		if (v < lo) begin
			c = lo;
		end else if (v > hi) begin
			c = hi;
		end else begin
			c = v;
		end
		return c - LIM_W'(1);
	endfunction

endpackage

// ===== rtl/core/rgb_to_yuv420_converter.sv =====
// Each accepted beat passes the input register, then the result register, to the
// output. Throughput: one pixel per cycle while the output is not stalled; the
// two registers form a two-stage pipeline, and the plane counters update once per
// accepted beat. Reset (arst_n low, asynchronous): both stages empty, counters and
// plane indices zero, frame size back to 640 x 480.
module rgb_to_yuv420_converter import ryc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [REG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [PIX_W-1:0]         red,
	input  logic [PIX_W-1:0]         green,
	input  logic [PIX_W-1:0]         blue,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [PIX_W-1:0]         luma,
	output logic [LUMA_ADDR_W-1:0]   luma_address,
	output logic                     chroma_valid,
	output logic [PIX_W-1:0]         blue_difference,
	output logic [PIX_W-1:0]         red_difference,
	output logic [CHROMA_ADDR_W-1:0] chroma_address,
	output logic                     frame_end
);

	logic             in_accept;
	logic             adv_s2;
	pos_t             pos;
	logic             valid_s1;
	logic [PIX_W-1:0] red_s1;
	logic [PIX_W-1:0] green_s1;
	logic [PIX_W-1:0] blue_s1;
	pos_t             pos_s1;
	logic             valid_s2;
	pos_t             pos_s2;
	logic [PIX_W-1:0] luma_c;
	logic [PIX_W-1:0] cb_c;
	logic [PIX_W-1:0] cr_c;
	logic [PIX_W-1:0] luma_s2;
	logic [PIX_W-1:0] cb_s2;
	logic [PIX_W-1:0] cr_s2;

	assign adv_s2    = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || adv_s2;
	assign in_accept = in_valid && in_ready;

	ryc_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_accept),
		.pos       (pos)
	);

	ryc_color u_color (
		.red             (red_s1),
		.green           (green_s1),
		.blue            (blue_s1),
		.sample          (pos_s1.chroma_valid),
		.luma            (luma_c),
		.blue_difference (cb_c),
		.red_difference  (cr_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// capture the pixel and its plane position on the accepted beat; load the results as stage 2 advances
	always_ff @(posedge clk) begin
		if (in_accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			pos_s1   <= pos;
		end
		if (adv_s2 && valid_s1) begin
			luma_s2 <= luma_c;
			cb_s2   <= cb_c;
			cr_s2   <= cr_c;
			pos_s2  <= pos_s1;
		end
	end

	assign out_valid       = valid_s2;
	assign luma            = luma_s2;
	assign luma_address    = pos_s2.luma_address;
	assign chroma_valid    = pos_s2.chroma_valid;
	assign blue_difference = cb_s2;
	assign red_difference  = cr_s2;
	assign chroma_address  = pos_s2.chroma_address;
	assign frame_end       = pos_s2.frame_end;

endmodule

// ===== rtl/core/ryc_raster.sv =====
module ryc_raster import ryc_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]       cfg_data,
	input  logic                   advance,
	output pos_t                   pos
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	localparam logic [LIM_W-1:0] WM1_RST =
		clamp_m1(LIM_W'(DEF_FRAME_WIDTH), LIM_W'(MIN_FRAME_WIDTH), LIM_W'(MAX_WIDTH));
	localparam logic [LIM_W-1:0] HM1_RST =
		clamp_m1(LIM_W'(DEF_FRAME_HEIGHT), LIM_W'(MIN_FRAME_HEIGHT), LIM_W'(MAX_HEIGHT));

	logic [COL_W-1:0]         width_m1_q;
	logic [ROW_W-1:0]         height_m1_q;
	logic [COL_W-1:0]         column_q;
	logic [ROW_W-1:0]         line_q;
	logic [LUMA_ADDR_W-1:0]   luma_index_q;
	logic [CHROMA_ADDR_W-1:0] chroma_index_q;

	logic [LIM_W-1:0] cfg_ext;
	logic [LIM_W-1:0] width_lim;
	logic [LIM_W-1:0] height_lim;
	logic             line_end;
	logic             frame_end;
	logic             sample;

	assign cfg_ext    = LIM_W'(cfg_data);
	assign width_lim  = clamp_m1(cfg_ext, LIM_W'(MIN_FRAME_WIDTH), LIM_W'(MAX_WIDTH));
	assign height_lim = clamp_m1(cfg_ext, LIM_W'(MIN_FRAME_HEIGHT), LIM_W'(MAX_HEIGHT));
	assign line_end   = column_q >= width_m1_q;
	assign frame_end  = line_end && (line_q >= height_m1_q);
	assign sample     = !column_q[0] && !line_q[0];

	always_comb begin
		pos.luma_address   = luma_index_q;
		pos.chroma_valid   = sample;
		pos.chroma_address = sample ? chroma_index_q : '0;
		pos.frame_end      = frame_end;
	end

	// limits are kept saturated and minus one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_m1_q  <= WM1_RST[COL_W-1:0];
			height_m1_q <= HM1_RST[ROW_W-1:0];
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH: begin
					width_m1_q <= width_lim[COL_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					height_m1_q <= height_lim[ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q       <= '0;
			line_q         <= '0;
			luma_index_q   <= '0;
			chroma_index_q <= '0;
		end else if (advance) begin
			if (frame_end) begin
				column_q       <= '0;
				line_q         <= '0;
				luma_index_q   <= '0;
				chroma_index_q <= '0;
			end else begin
				luma_index_q <= luma_index_q + LUMA_ADDR_W'(1);
				if (sample) begin
					chroma_index_q <= chroma_index_q + CHROMA_ADDR_W'(1);
				end
				if (line_end) begin
					column_q <= '0;
					line_q   <= line_q + ROW_W'(1);
				end else begin
					column_q <= column_q + COL_W'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/core/ryc_color.sv =====
module ryc_color import ryc_pkg::*; (
	input  logic [PIX_W-1:0] red,
	input  logic [PIX_W-1:0] green,
	input  logic [PIX_W-1:0] blue,
	input  logic             sample,
	output logic [PIX_W-1:0] luma,
	output logic [PIX_W-1:0] blue_difference,
	output logic [PIX_W-1:0] red_difference
);

	logic [15:0] r16;
	logic [15:0] g16;
	logic [15:0] b16;
	logic [15:0] y_sum;
	logic [15:0] cb_sum;
	logic [15:0] cr_sum;

	always_comb begin
		r16 = 16'(red);
		g16 = 16'(green);
		b16 = 16'(blue);
		y_sum = 16'd66 * r16 + 16'd129 * g16 + 16'd25 * b16;
		// bias by 128 << 8 first: the sum stays positive, so the shift is a floor
		cb_sum = 16'd32768 + 16'd112 * b16 - 16'd38 * r16 - 16'd74 * g16;
		cr_sum = 16'd32768 + 16'd112 * r16 - 16'd94 * g16 - 16'd18 * b16;
		luma = y_sum[15:8] + 8'd16;
		blue_difference = sample ? cb_sum[15:8] : '0;
		red_difference  = sample ? cr_sum[15:8] : '0;
	end

endmodule

// ===== rtl/core/ryc_checker.sv =====
module ryc_checker import ryc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [PIX_W-1:0]         luma,
	input logic [LUMA_ADDR_W-1:0]   luma_address,
	input logic                     chroma_valid,
	input logic [PIX_W-1:0]         blue_difference,
	input logic [PIX_W-1:0]         red_difference,
	input logic [CHROMA_ADDR_W-1:0] chroma_address
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(luma_address) && $stable(luma))
		else $error("result beat changed while stalled");

	// pixels without a chroma sample carry zero chroma fields
	a_no_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chroma_valid |->
			blue_difference == '0 && red_difference == '0 && chroma_address == '0)
		else $error("chroma fields set without a chroma sample");

	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> luma >= 8'd16 && luma <= 8'd235)
		else $error("luma out of range");

	a_chroma_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && chroma_valid |->
			blue_difference >= 8'd16 && blue_difference <= 8'd239 &&
			red_difference >= 8'd16 && red_difference <= 8'd239)
		else $error("chroma out of range");

endmodule

bind rgb_to_yuv420_converter ryc_checker u_ryc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.luma            (luma),
	.luma_address    (luma_address),
	.chroma_valid    (chroma_valid),
	.blue_difference (blue_difference),
	.red_difference  (red_difference),
	.chroma_address  (chroma_address)
);

// ===== verif/rgb_to_yuv420_converter_tb.sv =====
module rgb_to_yuv420_converter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ryc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [PIX_W-1:0]         luma;
		logic [LUMA_ADDR_W-1:0]   luma_address;
		logic                     chroma_valid;
		logic [PIX_W-1:0]         blue_difference;
		logic [PIX_W-1:0]         red_difference;
		logic [CHROMA_ADDR_W-1:0] chroma_address;
		logic                     frame_end;
	} yuv_pixel_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	cfg_reg_t                 cfg_index = REG_FRAME_WIDTH;
	logic [REG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [PIX_W-1:0]         red = '0;
	logic [PIX_W-1:0]         green = '0;
	logic [PIX_W-1:0]         blue = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [PIX_W-1:0]         luma;
	logic [LUMA_ADDR_W-1:0]   luma_address;
	logic                     chroma_valid;
	logic [PIX_W-1:0]         blue_difference;
	logic [PIX_W-1:0]         red_difference;
	logic [CHROMA_ADDR_W-1:0] chroma_address;
	logic                     frame_end;

	// converter state as seen from outside
	logic [REG_W-1:0]         width_setting = REG_W'(DEF_FRAME_WIDTH);
	logic [REG_W-1:0]         height_setting = REG_W'(DEF_FRAME_HEIGHT);
	logic [11:0]              column_pos = '0;
	logic [11:0]              line_pos = '0;
	logic [LUMA_ADDR_W-1:0]   luma_pos = '0;
	logic [CHROMA_ADDR_W-1:0] chroma_pos = '0;

	yuv_pixel_t pending_pixels[$];
	int errors = 0;
	int sent_pixels = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	rgb_to_yuv420_converter uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.luma            (luma),
		.luma_address    (luma_address),
		.chroma_valid    (chroma_valid),
		.blue_difference (blue_difference),
		.red_difference  (red_difference),
		.chroma_address  (chroma_address),
		.frame_end       (frame_end)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic convert_pixel(input logic [PIX_W-1:0] r, g, b);
		int w, h, ri, gi, bi, cb_sum, cr_sum;
		logic line_done;
		yuv_pixel_t px;
		ri = r;
		gi = g;
		bi = b;
		w = width_setting;
		h = height_setting;
		if (w < MIN_FRAME_WIDTH) w = MIN_FRAME_WIDTH;
		if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
		if (h < MIN_FRAME_HEIGHT) h = MIN_FRAME_HEIGHT;
		if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
		px = '0;
		px.luma = PIX_W'(((66 * ri + 129 * gi + 25 * bi) >>> 8) + 16);
		px.luma_address = luma_pos;
		px.chroma_valid = !line_pos[0] && !column_pos[0];
		line_done = int'(column_pos) >= w - 1;
		px.frame_end = line_done && (int'(line_pos) >= h - 1);
		if (px.chroma_valid) begin
			cb_sum = -38 * ri - 74 * gi + 112 * bi;
			cr_sum = 112 * ri - 94 * gi - 18 * bi;
			// arithmetic shift rounds toward minus infinity
			px.blue_difference = PIX_W'((cb_sum >>> 8) + 128);
			px.red_difference = PIX_W'((cr_sum >>> 8) + 128);
			px.chroma_address = chroma_pos;
		end
		pending_pixels.push_back(px);
		if (px.frame_end) begin
			column_pos = '0;
			line_pos = '0;
			luma_pos = '0;
			chroma_pos = '0;
		end else begin
			luma_pos = luma_pos + 1'b1;
			if (px.chroma_valid) chroma_pos = chroma_pos + 1'b1;
			if (line_done) begin
				column_pos = '0;
				line_pos = line_pos + 1'b1;
			end else begin
				column_pos = column_pos + 1'b1;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_WIDTH) width_setting = cfg_data;
				else height_setting = cfg_data;
			end
			if (in_valid && in_ready) convert_pixel(red, green, blue);
		end
	end

	task automatic compare_field(input string field, input logic [31:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_results
		yuv_pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected output beat, expected none, got luma %0d at %0d",
					$time, luma, luma_address);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				compare_field("luma", want.luma, luma);
				compare_field("luma_address", want.luma_address, luma_address);
				compare_field("chroma_valid", want.chroma_valid, chroma_valid);
				compare_field("blue_difference", want.blue_difference, blue_difference);
				compare_field("red_difference", want.red_difference, red_difference);
				compare_field("chroma_address", want.chroma_address, chroma_address);
				compare_field("frame_end", want.frame_end, frame_end);
			end
		end
	end

	// output side: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		red <= r;
		green <= g;
		blue <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_pixels++;
	endtask

	task automatic send_random_pixel();
		send_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
			PIX_W'($urandom_range(255)));
	endtask

	// drop valid and let the pipeline empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= REG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input int w, h);
		wait_idle();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// run past the first line end of the power-up frame size
	task automatic test_reset_size();
		send_idle_pct = 7;
		recv_idle_pct = 69;
		repeat (DEF_FRAME_WIDTH + 5) send_random_pixel();
	endtask

	task automatic test_directed_corners();
		send_idle_pct = 7;
		recv_idle_pct = 69;
		// below range: saturates to 2 x 1, every second pixel ends a frame
		set_frame(0, 0);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		// above range: saturates to the maximum size
		set_frame(8191, 8191);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd128, 8'd64, 8'd200);
		// shrink mid-line to an odd width: the line ends at once
		set_frame(3, 2);
		repeat (7) send_random_pixel();
		set_frame(4097, 1);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		set_frame(1, 4096);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd17, 8'd99, 8'd240);
		send_pixel(8'd255, 8'd255, 8'd255);
	endtask

	task automatic test_random_frames(input int send_pct, recv_pct, count);
		int target, w, h, n, pick;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = sent_pixels + count;
		while (sent_pixels < target) begin
			pick = $urandom_range(19);
			if (pick == 0) begin
				w = $urandom_range(8191);
				h = $urandom_range(8191);
			end else if (pick == 1) begin
				w = DEF_MAX_WIDTH;
				h = $urandom_range(1, 2) == 1 ? 1 : DEF_MAX_HEIGHT;
			end else if (pick == 2) begin
				w = 2 * $urandom_range(1, 7) + 1;
				h = $urandom_range(1, 5);
			end else begin
				w = 2 * $urandom_range(1, 8);
				h = $urandom_range(1, 5);
			end
			set_frame(w, h);
			// random or maximum sizes: at most 40 pixels, usually ending mid-frame
			if (pick < 2) n = $urandom_range(1, 40);
			else if (pick == 3) n = $urandom_range(1, w * h);
			else n = $urandom_range(w * h, 3 * w * h);
			repeat (n) send_random_pixel();
		end
	endtask

	// hold the output long enough that the input stalls
	task automatic test_backpressure();
		set_frame(10, 4);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 300;
		repeat (60) send_random_pixel();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_directed_corners();
		test_random_frames(7, 69, 380);
		test_random_frames(69, 7, 380);
		test_random_frames(0, 0, 380);
		test_backpressure();
		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
